// File: rtl/core/ring_area_perimeter_meter_macros.svh
`ifndef RING_AREA_PERIMETER_METER_MACROS_SVH
`define RING_AREA_PERIMETER_METER_MACROS_SVH

// overlapping implication, checked outside reset
`define RAPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RAPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define RAPM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rapm_pkg.sv
`default_nettype none
package rapm_pkg;
    localparam int COORD_WIDTH_DEF = 62;
    localparam int FIELD_W         = 62;
    localparam int IN_DATA_W       = 128;
    localparam int IN_USER_W       = 3;
    localparam int OUT_DATA_W      = 192;
    localparam int PERIM_W         = 63;
    localparam int SQRT_STEPS      = 64;
    localparam int NUM_SQ_OPS      = 6;
    localparam int NUM_ALL_OPS     = 12;

    localparam logic [1:0] ROLE_OPEN     = 2'd0;
    localparam logic [1:0] ROLE_EXTERIOR = 2'd1;
    localparam logic [1:0] ROLE_INTERIOR = 2'd2;

    localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};

    typedef enum logic [3:0] {
        MOP_SQ_X00, MOP_SQ_X01, MOP_SQ_X11,
        MOP_SQ_Y00, MOP_SQ_Y01, MOP_SQ_Y11,
        MOP_AR_P00, MOP_AR_P01, MOP_AR_P10,
        MOP_AR_N00, MOP_AR_N01, MOP_AR_N10
    } t_mop;

    typedef struct packed {
        logic load;
        logic setup_open;
        logic setup_close;
        logic mop_valid;
        t_mop mop;
        logic sqrt_start;
        logic perim_add;
        logic advance;
        logic fin_area;
        logic fin_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cc_zero;
        logic cc_full;
        logic ring_end;
        logic closed;
        logic sqrt_done;
        logic out_free;
    } t_dp_sts;
endpackage
`default_nettype wire

// File: rtl/core/rapm_sqrt.sv
`default_nettype none
module rapm_sqrt import rapm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_value,
    output logic              o_done,
    output logic [63:0]       o_root
);
    localparam int REST_W = 68;
    localparam int CNT_W  = $clog2(SQRT_STEPS);

    logic [127:0]      r_v;
    logic [REST_W-1:0] r_rest;
    logic [63:0]       r_root;
    logic [63:0]       r_len;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_rnd;
    logic              r_done;
    logic [REST_W-1:0] rest_sh;
    logic [REST_W-1:0] trial;

    assign rest_sh = {r_rest[REST_W-3:0], r_v[127:126]};
    assign trial   = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_rnd  <= 1'b1;
            end
        end else if (r_rnd) begin
            r_rnd  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rest <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_v   <= {r_v[125:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (rest_sh >= trial) begin
                r_rest <= rest_sh - trial;
                r_root <= {r_root[62:0], 1'b1};
            end else begin
                r_rest <= rest_sh;
                r_root <= {r_root[62:0], 1'b0};
            end
        end else if (r_rnd) begin
            r_len <= (r_rest > {4'b0000, r_root}) ? r_root + 64'd1 : r_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_len;
endmodule
`default_nettype wire

// File: rtl/core/rapm_datapath.sv
`default_nettype none
module rapm_datapath import rapm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic [IN_USER_W-1:0]  i_in_user,
    input  wire logic                  i_in_last,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic                       o_out_last
);
    function automatic logic [63:0] sext(input logic [FIELD_W-1:0] v);
        return {{(64-COORD_WIDTH){v[COORD_WIDTH-1]}}, v[COORD_WIDTH-1:0]};
    endfunction

    function automatic logic [63:0] absd(input logic [63:0] a, input logic [63:0] b);
        return ($signed(a) >= $signed(b)) ? a - b : b - a;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] halve(input logic [63:0] t);
        logic [64:0] h;
        h = ({1'b0, mag(t)} + 65'd1) >> 1;
        return t[63] ? (~h[63:0] + 64'd1) : h[63:0];
    endfunction

    logic [63:0]        r_cx, r_cy, r_ox, r_oy, r_px, r_py;
    logic [1:0]         r_role;
    logic               r_rend, r_send;
    logic [1:0]         r_cc;
    logic [63:0]        r_dx, r_dy, r_ax, r_ay, r_bx, r_by;
    logic [127:0]       r_sq;
    logic [63:0]        r_ring, r_slot, r_ring_out;
    logic [PERIM_W-1:0] r_perim;
    logic [63:0]        r_prod;
    t_mop               r_mop_q;
    logic               r_mac_v;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic               r_out_last;

    logic [63:0] in_x, in_y;
    logic [31:0] mul_a, mul_b;
    logic        closed;
    logic [63:0] sq_len;
    logic        sq_done;
    logic [64:0] perim_sum;

    assign in_x   = sext(i_in_data[FIELD_W-1:0]);
    assign in_y   = sext(i_in_data[2*FIELD_W-1:FIELD_W]);
    assign closed = (r_role == ROLE_EXTERIOR) || (r_role == ROLE_INTERIOR);
    assign perim_sum = {2'b00, r_perim} + {1'b0, sq_len};

    always_comb begin
        case (i_cmd.mop)
            MOP_SQ_X00: begin mul_a = r_dx[31:0];  mul_b = r_dx[31:0];  end
            MOP_SQ_X01: begin mul_a = r_dx[31:0];  mul_b = r_dx[63:32]; end
            MOP_SQ_X11: begin mul_a = r_dx[63:32]; mul_b = r_dx[63:32]; end
            MOP_SQ_Y00: begin mul_a = r_dy[31:0];  mul_b = r_dy[31:0];  end
            MOP_SQ_Y01: begin mul_a = r_dy[31:0];  mul_b = r_dy[63:32]; end
            MOP_SQ_Y11: begin mul_a = r_dy[63:32]; mul_b = r_dy[63:32]; end
            MOP_AR_P00: begin mul_a = r_ax[31:0];  mul_b = r_by[31:0];  end
            MOP_AR_P01: begin mul_a = r_ax[31:0];  mul_b = r_by[63:32]; end
            MOP_AR_P10: begin mul_a = r_ax[63:32]; mul_b = r_by[31:0];  end
            MOP_AR_N00: begin mul_a = r_bx[31:0];  mul_b = r_ay[31:0];  end
            MOP_AR_N01: begin mul_a = r_bx[31:0];  mul_b = r_ay[63:32]; end
            MOP_AR_N10: begin mul_a = r_bx[63:32]; mul_b = r_ay[31:0];  end
            default:    begin mul_a = '0;          mul_b = '0;          end
        endcase
    end

    rapm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_sq),
        .o_done  (sq_done),
        .o_root  (sq_len)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= in_x;
            r_cy   <= in_y;
            r_role <= i_in_user[1:0];
            r_rend <= i_in_last | i_in_user[2];
            r_send <= i_in_user[2];
            if (r_cc == 2'd0) begin
                r_ox <= in_x;
                r_oy <= in_y;
            end
        end
        if (i_cmd.setup_open) begin
            r_dx <= absd(r_px, r_cx);
            r_dy <= absd(r_py, r_cy);
            r_ax <= r_px - r_ox;
            r_ay <= r_py - r_oy;
            r_bx <= r_cx - r_ox;
            r_by <= r_cy - r_oy;
        end
        if (i_cmd.setup_close) begin
            r_dx <= absd(r_cx, r_ox);
            r_dy <= absd(r_cy, r_oy);
        end
        if (i_cmd.advance) begin
            r_px <= r_cx;
            r_py <= r_cy;
        end
        r_prod  <= 64'(mul_a) * 64'(mul_b);
        r_mop_q <= i_cmd.mop;
        if (i_cmd.fin_area) begin
            r_ring_out <= closed ? halve(r_ring) : 64'd0;
        end
        if (i_cmd.fin_emit) begin
            r_out_data <= {1'b0, r_perim, halve(r_slot), r_ring_out};
            r_out_last <= r_send;
        end
        if (i_cmd.setup_open || i_cmd.setup_close) begin
            r_sq <= '0;
        end else if (r_mac_v) begin
            case (r_mop_q)
                MOP_SQ_X00, MOP_SQ_Y00: r_sq <= r_sq + 128'(r_prod);
                MOP_SQ_X01, MOP_SQ_Y01: r_sq <= r_sq + (128'(r_prod) << 33);
                MOP_SQ_X11, MOP_SQ_Y11: r_sq <= r_sq + (128'(r_prod) << 64);
                default: r_sq <= r_sq;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc        <= 2'd0;
            r_ring      <= '0;
            r_slot      <= '0;
            r_perim     <= '0;
            r_mac_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mac_v <= i_cmd.mop_valid;
            if (r_mac_v) begin
                case (r_mop_q)
                    MOP_AR_P00: r_ring <= r_ring + r_prod;
                    MOP_AR_P01, MOP_AR_P10: r_ring <= r_ring + {r_prod[31:0], 32'd0};
                    MOP_AR_N00: r_ring <= r_ring - r_prod;
                    MOP_AR_N01, MOP_AR_N10: r_ring <= r_ring - {r_prod[31:0], 32'd0};
                    default: r_ring <= r_ring;
                endcase
            end
            if (i_cmd.advance && r_cc != 2'd3) begin
                r_cc <= r_cc + 2'd1;
            end
            if (i_cmd.perim_add) begin
                r_perim <= (perim_sum > {2'b00, PERIM_MAX}) ? PERIM_MAX
                                                           : perim_sum[PERIM_W-1:0];
            end
            if (i_cmd.fin_area && closed) begin
                if (r_role == ROLE_INTERIOR) begin
                    r_slot <= r_slot - mag(r_ring);
                end else begin
                    r_slot <= r_slot + mag(r_ring);
                end
            end
            if (i_cmd.fin_emit) begin
                r_out_valid <= 1'b1;
                r_cc        <= 2'd0;
                r_ring      <= '0;
                if (r_send) begin
                    r_slot  <= '0;
                    r_perim <= '0;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cc_zero   = (r_cc == 2'd0);
    assign o_sts.cc_full   = (r_cc == 2'd3);
    assign o_sts.ring_end  = r_rend;
    assign o_sts.closed    = closed;
    assign o_sts.sqrt_done = sq_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
endmodule
`default_nettype wire

// File: rtl/core/rapm_ctrl.sv
`default_nettype none
module rapm_ctrl import rapm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_SETUP_OPEN, S_SETUP_CLOSE, S_MUL, S_DRAIN, S_SQRT_GO,
        S_SQRT_WAIT, S_PERIM, S_ADVANCE, S_RCHK, S_FIN_AREA, S_FIN_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_closing, n_closing;
    logic       r_ready;
    logic       last_op;

    assign last_op = r_closing ? (r_step == 4'(NUM_SQ_OPS - 1))
                               : (r_step == 4'(NUM_ALL_OPS - 1));

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_closing = r_closing;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    n_state = i_sts.cc_zero ? S_ADVANCE : S_SETUP_OPEN;
                end
            end
            S_SETUP_OPEN: begin
                n_step = '0; n_closing = 1'b0; n_state = S_MUL;
            end
            S_SETUP_CLOSE: begin
                n_step = '0; n_closing = 1'b1; n_state = S_MUL;
            end
            S_MUL: begin
                if (last_op) n_state = S_DRAIN;
                else n_step = r_step + 4'd1;
            end
            S_DRAIN:     n_state = S_SQRT_GO;
            S_SQRT_GO:   n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: if (i_sts.sqrt_done) n_state = S_PERIM;
            S_PERIM:     n_state = r_closing ? S_FIN_AREA : S_ADVANCE;
            S_ADVANCE:   n_state = S_RCHK;
            S_RCHK: begin
                if (!i_sts.ring_end) n_state = S_IDLE;
                else if (i_sts.closed && i_sts.cc_full) n_state = S_SETUP_CLOSE;
                else n_state = S_FIN_AREA;
            end
            S_FIN_AREA:  n_state = S_FIN_EMIT;
            S_FIN_EMIT:  if (i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_closing <= 1'b0;
            r_ready   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_closing <= n_closing;
            r_ready   <= (n_state == S_IDLE) && !(r_state == S_IDLE && i_in_valid && r_ready);
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.mop         = t_mop'(r_step);
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid && r_ready;
        o_cmd.setup_open  = (r_state == S_SETUP_OPEN);
        o_cmd.setup_close = (r_state == S_SETUP_CLOSE);
        o_cmd.mop_valid   = (r_state == S_MUL);
        o_cmd.sqrt_start  = (r_state == S_SQRT_GO);
        o_cmd.perim_add   = (r_state == S_PERIM);
        o_cmd.advance     = (r_state == S_ADVANCE);
        o_cmd.fin_area    = (r_state == S_FIN_AREA);
        o_cmd.fin_emit    = (r_state == S_FIN_EMIT) && i_sts.out_free;
    end

    assign o_in_ready = r_ready;
endmodule
`default_nettype wire

// File: rtl/core/ring_area_perimeter_meter.sv
// ring area and perimeter meter
// input stream: one vertex per transaction; s_axis_tdata holds x and y,
// s_axis_tlast marks the ring's last vertex, s_axis_tuser holds the ring
// role and the slot end flag (slot end also ends the ring)
// output stream: one transaction per ring end with the ring area, the
// running slot area and the running slot perimeter; m_axis_tlast closes
// the slot
// the first vertex of a ring is only stored; every later vertex takes
// 12 passes through one 32x32 multiplier and then the shared
// digit-by-digit square root unit (64 steps and rounding)
// a closed ring of three or more corners adds, at its end, the squares
// and the root of the closing side before the result is posted
// a new vertex is taken only once the last one is through
// reset clears all running sums and the output valid flag; no clearing pass
// a stalled receiver holds the result in the output register while the
// next vertex is taken; only the following ring end waits for it
`default_nettype none
module ring_area_perimeter_meter import rapm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // x, y, zero pad
    input  wire logic                  s_axis_tlast,   // ring_end
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // role, slot_end
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // ring_area_mm2, slot_area_mm2,
                                                       // slot_perimeter_mm, zero pad
    output logic                       m_axis_tlast    // slot_done
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    rapm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rapm_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );
endmodule
`default_nettype wire

// File: rtl/core/rapm_checker.sv
`default_nettype none
`include "ring_area_perimeter_meter_macros.svh"
module rapm_checker import rapm_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);
    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    `RAPM_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")
    `RAPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output dropped or changed while stalled")
    `RAPM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_xfer, !s_axis_tready, "ready right after an input transaction")
    `RAPM_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_xfer, !$rose(m_axis_tvalid), "result one cycle after input")
    `RAPM_ASSERT_SAME(a_busy_no_pad, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[OUT_DATA_W-1], "output pad bit set")
endmodule

bind ring_area_perimeter_meter rapm_checker u_rapm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;
    import rapm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [61:0] COORD_MAX = 62'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [61:0] COORD_MIN = 62'h2000_0000_0000_0001;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 3000;

    typedef struct packed {
        logic signed [63:0] ring_mm2;
        logic signed [63:0] slot_area;
        logic [62:0]        perimeter;
        logic               done;
    } t_meas;

    typedef struct packed {
        logic [61:0] x;
        logic [61:0] y;
        logic [1:0]  role;
        logic        ring_end;
        logic        slot_end;
        logic        has_typed;
        t_meas       typed;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // x, y, zero pad
    logic s_axis_tlast = 1'b0;                 // ring_end
    logic [IN_USER_W-1:0] s_axis_tuser = '0;   // role, slot_end
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // ring_area, slot_area, perimeter, zero pad
    logic m_axis_tlast;                        // slot_done

    ring_area_perimeter_meter dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] org_x, org_y, prev_x, prev_y;
    logic [1:0]  corners;
    logic [63:0] ring_twice, slot_twice;
    logic [62:0] perim_sum;

    t_meas   expected_meas[$];
    t_vertex sent_vertices[$];
    int tx_idle = 11, rx_idle = 47;
    int errors = 0, items = 0, rings = 0, slots = 0, quiet_cycles = 0;
    bit hold_request = 1'b0;

    function automatic logic [63:0] sqrt_round(input logic [127:0] v);
        logic [127:0] rest, trial;
        logic [63:0] root;
        rest = '0;
        root = '0;
        for (int i = 0; i < 64; i++) begin
            rest = {rest[125:0], v[127:126]};
            v = v << 2;
            trial = {62'd0, root, 2'b01};
            root = root << 1;
            if (rest >= trial) begin
                rest = rest - trial;
                root[0] = 1'b1;
            end
        end
        return (rest > {64'd0, root}) ? root + 64'd1 : root;
    endfunction

    function automatic logic [63:0] side_len(input logic [63:0] ax, ay, bx, by);
        logic [63:0] dx, dy;
        dx = ($signed(ax) >= $signed(bx)) ? ax - bx : bx - ax;
        dy = ($signed(ay) >= $signed(by)) ? ay - by : by - ay;
        return sqrt_round({64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy});
    endfunction

    function automatic void add_side(input logic [63:0] len);
        logic [63:0] s;
        s = {1'b0, perim_sum} + len;
        perim_sum = (len > {1'b0, PERIM_MAX} || s > {1'b0, PERIM_MAX}) ? PERIM_MAX : s[62:0];
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] halve(input logic [63:0] twice);
        logic [63:0] h;
        h = (mag(twice) + 64'd1) >> 1;
        return twice[63] ? -h : h;
    endfunction

    function automatic bit measure_vertex(input t_vertex vt, output t_meas m);
        logic [63:0] x, y;
        bit slot_end, ring_end, closed;
        x = {{2{vt.x[61]}}, vt.x};
        y = {{2{vt.y[61]}}, vt.y};
        slot_end = vt.slot_end;
        ring_end = vt.ring_end || slot_end;
        closed = (vt.role == ROLE_EXTERIOR || vt.role == ROLE_INTERIOR);
        m = '0;
        if (corners == 2'd0) begin
            org_x = x;
            org_y = y;
        end else begin
            ring_twice += (prev_x - org_x) * (y - org_y) - (x - org_x) * (prev_y - org_y);
            add_side(side_len(prev_x, prev_y, x, y));
        end
        prev_x = x;
        prev_y = y;
        if (corners != 2'd3) corners++;
        if (!ring_end) return 1'b0;
        if (closed && corners == 2'd3) add_side(side_len(x, y, org_x, org_y));
        if (closed) begin
            m.ring_mm2 = halve(ring_twice);
            if (vt.role == ROLE_INTERIOR) slot_twice -= mag(ring_twice);
            else slot_twice += mag(ring_twice);
        end
        m.slot_area = halve(slot_twice);
        m.perimeter = perim_sum;
        m.done = slot_end;
        corners = 2'd0;
        ring_twice = '0;
        if (slot_end) begin
            slot_twice = '0;
            perim_sum = '0;
        end
        return 1'b1;
    endfunction

    // input side: predict on every accepted vertex
    always @(posedge i_clk) begin
        t_vertex vt;
        t_meas m;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            vt = sent_vertices.pop_front();
            items++;
            if (measure_vertex(vt, m)) begin
                rings++;
                if (m.done) slots++;
                expected_meas = {expected_meas, (vt.has_typed ? vt.typed : m)};
            end
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge i_clk) begin
        t_meas e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_meas.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
            end else begin
                e = expected_meas.pop_front();
                if (m_axis_tdata[63:0] !== e.ring_mm2) begin
                    $error("ring_area_mm2 exp %0d got %0d", e.ring_mm2,
                           $signed(m_axis_tdata[63:0]));
                    errors++;
                end
                if (m_axis_tdata[127:64] !== e.slot_area) begin
                    $error("slot_area_mm2 exp %0d got %0d", e.slot_area,
                           $signed(m_axis_tdata[127:64]));
                    errors++;
                end
                if (m_axis_tdata[190:128] !== e.perimeter) begin
                    $error("slot_perimeter_mm exp %0d got %0d", e.perimeter,
                           m_axis_tdata[190:128]);
                    errors++;
                end
                if (m_axis_tlast !== e.done) begin
                    $error("slot_done exp %0b got %0b", e.done, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge i_clk) begin
        int hold;
        if (hold_request && hold == 0) begin
            hold_request <= 1'b0;
            hold = HOLD_OFF_CYCLES;
        end
        if (hold > 0) begin
            hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_vertex(input t_vertex vt);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        sent_vertices = {sent_vertices, vt};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, vt.y, vt.x};
        s_axis_tlast <= vt.ring_end;
        s_axis_tuser <= {vt.slot_end, vt.role};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [61:0] rand_coord(input int scale);
        logic [61:0] c;
        case (scale)
            0: c = 62'($signed($urandom_range(2000)) - 1000);
            1: c = 62'($signed($urandom_range(2097152)) - 1048576);
            default: begin
                c = 62'({$urandom, $urandom});
                if (c == 62'h2000_0000_0000_0000) c = COORD_MIN;
            end
        endcase
        return c;
    endfunction

    task automatic send_random_ring();
        t_vertex vt;
        int n, scale, pick;
        logic [1:0] role;
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        pick = $urandom_range(99);
        role = (pick < 55) ? ROLE_EXTERIOR : (pick < 85) ? ROLE_INTERIOR :
               (pick < 95) ? ROLE_OPEN : 2'd3;
        pick = $urandom_range(99);
        scale = (pick < 70) ? 0 : (pick < 95) ? 1 : 2;
        for (int i = 0; i < n; i++) begin
            vt = '0;
            vt.x = rand_coord(scale);
            vt.y = rand_coord(scale);
            vt.role = (i == n - 1) ? role : 2'($urandom_range(3));
            if (i == n - 1) begin
                vt.slot_end = ($urandom_range(99) < 30);
                vt.ring_end = !(vt.slot_end && $urandom_range(9) == 0);
            end
            send_vertex(vt);
        end
    endtask

    function automatic t_vertex vtx(input logic [61:0] x, y, input logic [1:0] role,
                                    input int re, se, ht, input t_meas tm);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.role = role;
        v.ring_end = (re != 0);
        v.slot_end = (se != 0);
        v.has_typed = (ht != 0);
        v.typed = tm;
        return v;
    endfunction

    t_vertex directed[$];

    function automatic void add_row(input t_vertex v);
        directed = {directed, v};
    endfunction

    initial begin
        org_x = '0; org_y = '0; prev_x = '0; prev_y = '0;
        corners = '0; ring_twice = '0; slot_twice = '0; perim_sum = '0;
        // lone vertex closing a slot
        add_row(vtx(0, 0, ROLE_EXTERIOR, 1, 1, 1, '{0, 0, 0, 1}));
        // ccw square, then cw hole
        add_row(vtx(0, 0, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(10, 0, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(10, 10, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(0, 10, ROLE_EXTERIOR, 1, 0, 1, '{100, 100, 40, 0}));
        add_row(vtx(2, 2, ROLE_INTERIOR, 0, 0, 0, '0));
        add_row(vtx(2, 4, ROLE_INTERIOR, 0, 0, 0, '0));
        add_row(vtx(4, 4, ROLE_INTERIOR, 0, 0, 0, '0));
        add_row(vtx(4, 2, ROLE_INTERIOR, 1, 1, 1, '{-4, 96, 48, 1}));
        // open polyline, then role three with slot end but no ring end
        add_row(vtx(0, 0, ROLE_OPEN, 0, 0, 0, '0));
        add_row(vtx(3, 4, ROLE_OPEN, 1, 0, 1, '{0, 0, 5, 0}));
        add_row(vtx(0, 0, 2'd3, 0, 0, 0, '0));
        add_row(vtx(5, 0, 2'd3, 0, 0, 0, '0));
        add_row(vtx(0, 5, 2'd3, 0, 1, 1, '{0, 0, 17, 1}));
        // two-vertex exterior ring
        add_row(vtx(1, 1, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(4, 5, ROLE_EXTERIOR, 1, 1, 1, '{0, 0, 5, 1}));
        // half-unit triangles, both windings
        add_row(vtx(0, 0, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(1, 0, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(0, 1, ROLE_EXTERIOR, 1, 0, 1, '{1, 1, 3, 0}));
        add_row(vtx(0, 0, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(0, 1, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(1, 0, ROLE_EXTERIOR, 1, 1, 1, '{-1, 1, 6, 1}));
        // extreme corners: area wrap and perimeter saturation
        add_row(vtx(COORD_MAX, COORD_MAX, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(COORD_MIN, COORD_MIN, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(COORD_MAX, COORD_MIN, ROLE_EXTERIOR, 0, 0, 0, '0));
        add_row(vtx(COORD_MIN, COORD_MAX, ROLE_EXTERIOR, 1, 1, 0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_vertex(directed[i]);

        while (items < 620) send_random_ring();
        hold_request = 1'b1;
        while (items < 1240) send_random_ring();
        tx_idle = 47;
        rx_idle = 11;
        while (items < 1550) send_random_ring();
        tx_idle = 0;
        rx_idle = 0;
        while (items < 1875) send_random_ring();
        s_axis_tvalid <= 1'b0;

        while (expected_meas.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (expected_meas.size() != 0) begin
            $error("%0d expected results never arrived", expected_meas.size());
            errors++;
        end
        $display("covered %0d vertices in %0d rings over %0d slots,", items, rings, slots);
        $display("with sender and receiver stalls and one long receiver hold-off");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
